@@ rtl/scsc_pkg.sv @@
`timescale 1ns / 1ps

package scsc_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int TRACE_SLOTS = 10;

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_W  = 4;
  localparam int CMD_W   = 2;
  localparam int WORD_W  = 32;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 184;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_CAPTURE = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAP_READ,
    ST_CAP_EMIT
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] col_num;
    logic [WORD_W-1:0] line_no;
    logic [WORD_W-1:0] type_id;
    logic [WORD_W-1:0] func_num;
    logic [WORD_W-1:0] file_id;
  } rec_t;

  typedef struct packed {
    logic               status;
    rec_t               rec;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  captured_count;
    logic [DEPTH_W-1:0] depth_now;
    logic               last_flag;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_take;
    logic cap_start;
    logic cap_emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic               out_free;
    logic               slot_last;
    logic [DEPTH_W-1:0] depth;
  } dp_sts_t;

endpackage

@@ rtl/scsc_ctrl.sv @@
`timescale 1ns / 1ps

module scsc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [scsc_pkg::CMD_W-1:0]      command,
  output logic                            in_ready,
  input  scsc_pkg::dp_sts_t               sts,
  output scsc_pkg::dp_cmd_t               cmd
);
  import scsc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.in_take   = 1'b0;
    cmd.cap_start = 1'b0;
    cmd.cap_emit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (command == CMD_CAPTURE) begin
            cmd.cap_start = 1'b1;
            state_next    = ST_CAP_READ;
          end else begin
            cmd.in_take = 1'b1;
          end
        end
      end
      ST_CAP_READ: begin
        state_next = ST_CAP_EMIT;
      end
      ST_CAP_EMIT: begin
        if (sts.out_free) begin
          cmd.cap_emit = 1'b1;
          state_next   = sts.slot_last ? ST_IDLE : ST_CAP_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/scsc_dpath.sv @@
`timescale 1ns / 1ps

module scsc_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  scsc_pkg::dp_cmd_t               cmd,
  output scsc_pkg::dp_sts_t               sts,
  input  logic [scsc_pkg::CMD_W-1:0]      command,
  input  scsc_pkg::rec_t                  in_rec,
  output logic                            out_valid,
  input  logic                            out_ready,
  output scsc_pkg::result_t               out_res
);
  import scsc_pkg::*;

  rec_t               mem [STACK_DEPTH];
  rec_t               rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;

  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  slot_next;
  logic               out_valid_next;
  result_t            out_res_next;
  logic [SLOT_W-1:0]  count;
  logic               full;
  logic               real_slot;

  assign full      = (depth == DEPTH_W'(STACK_DEPTH));
  assign count     = (depth < DEPTH_W'(TRACE_SLOTS)) ? depth[SLOT_W-1:0]
                                                     : SLOT_W'(TRACE_SLOTS);
  assign real_slot = (slot < count);
  assign rd_addr   = ADDR_W'(depth - DEPTH_W'(1) - DEPTH_W'(slot));

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.slot_last = (slot == SLOT_W'(TRACE_SLOTS - 1));
  assign sts.depth     = depth;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[depth[ADDR_W-1:0]] <= in_rec;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    depth_next     = depth;
    slot_next      = slot;
    mem_we         = 1'b0;
    out_valid_next = out_valid && !out_ready;
    out_res_next   = out_res;

    if (cmd.in_take) begin
      out_res_next                = '0;
      out_res_next.last_flag      = 1'b1;
      unique case (command)
        CMD_PUSH: begin
          if (full) begin
            out_res_next.status = 1'b1;
          end else begin
            mem_we     = 1'b1;
            depth_next = depth + DEPTH_W'(1);
          end
        end
        CMD_POP: begin
          if (depth != '0) begin
            depth_next = depth - DEPTH_W'(1);
          end
        end
        default: begin
        end
      endcase
      out_res_next.depth_now = depth_next;
      out_valid_next         = 1'b1;
    end

    if (cmd.cap_start) begin
      slot_next = '0;
    end

    if (cmd.cap_emit) begin
      out_res_next.status         = 1'b0;
      out_res_next.rec            = real_slot ? rd_data : '0;
      out_res_next.slot           = slot;
      out_res_next.captured_count = count;
      out_res_next.depth_now      = depth;
      out_res_next.last_flag      = sts.slot_last;
      out_valid_next              = 1'b1;
      slot_next                   = slot + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      depth     <= depth_next;
      slot      <= slot_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_res <= out_res_next;
  end

endmodule

@@ rtl/shadow_call_stack_capture_unit.sv @@
`timescale 1ns / 1ps

// Shadow call stack with trace capture.
// The slave channel takes one command per transaction: tuser holds the
// command (push, pop or capture) and tdata holds the record of a push.
// The master channel returns results: tuser is the overflow status, tlast
// marks the final result of a command, and tdata carries the record, slot,
// captured count and stack depth after the operation.
// A push, a pop or an unused command gives one result in the cycle after
// it is accepted, and a new command is accepted every cycle while the
// result register is drained each cycle.
// A capture gives ten results, newest record first, padded with zeros.
// Each slot passes through a read state for the registered stack memory
// read and an emit state that loads the result register, and no command
// is accepted while a capture runs.
// Reset clears the depth and all control state; the stack memory holds no
// reset value and its read data is only used below the depth.
// When the receiver stalls, the result holds and tready drops until the
// result register is free again.

module shadow_call_stack_capture_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // file_id, func_num, type_id, line_no, col_num
  input  logic [scsc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // command
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // rec_file, rec_routine, rec_type, rec_line, rec_column, slot,
  // captured_count, depth_now, zero fill
  output logic [scsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [0:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);
  import scsc_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  rec_t    in_rec;
  result_t out_res;

  assign in_rec.file_id  = s_axis_tdata[31:0];
  assign in_rec.func_num = s_axis_tdata[63:32];
  assign in_rec.type_id  = s_axis_tdata[95:64];
  assign in_rec.line_no  = s_axis_tdata[127:96];
  assign in_rec.col_num  = s_axis_tdata[159:128];

  scsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .command  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  scsc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .command   (s_axis_tuser),
    .in_rec    (in_rec),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {
    7'd0,
    out_res.depth_now,
    out_res.captured_count,
    out_res.slot,
    out_res.rec.col_num,
    out_res.rec.line_no,
    out_res.rec.type_id,
    out_res.rec.func_num,
    out_res.rec.file_id
  };
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.last_flag;

`ifndef SYNTH
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid && !m_axis_tready))
    else $error("command accepted while a stalled result is pending");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    dp_sts.depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_PUSH
     && dp_sts.depth != DEPTH_W'(STACK_DEPTH))
    |=> dp_sts.depth == $past(dp_sts.depth) + DEPTH_W'(1))
    else $error("accepted push did not raise the depth");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && out_res.slot != '0)
    |-> out_res.slot == SLOT_W'(TRACE_SLOTS - 1))
    else $error("capture run ended on a wrong slot");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import scsc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_IDLE = 17;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [183:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic m_axis_tlast;

  shadow_call_stack_capture_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  rec_t call_stack [STACK_DEPTH];
  int unsigned stack_level;
  result_t expected_results[$];

  int error_count = 0;
  int commands_sent;
  int results_checked = 0;
  int results_taken = 0;
  int results_paced;
  int captures_sent;
  int refused_pushes;
  int empty_pops;
  int peak_level;
  bit source_no_idle;
  bit sink_no_idle;
  int sink_wait;
  int sink_draw;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Works out the results of one accepted command and updates the stack copy.
  function automatic void predict_command(input logic [CMD_W-1:0] cmd, input rec_t rec);
    result_t res;
    int unsigned held;
    res = '0;
    res.last_flag = 1'b1;
    case (cmd)
      CMD_PUSH: begin
        if (stack_level >= STACK_DEPTH) begin
          res.status = 1'b1;
          refused_pushes++;
        end else begin
          call_stack[stack_level] = rec;
          stack_level++;
        end
        res.depth_now = DEPTH_W'(stack_level);
        expected_results.push_back(res);
      end
      CMD_POP: begin
        if (stack_level > 0) begin
          stack_level--;
        end else begin
          empty_pops++;
        end
        res.depth_now = DEPTH_W'(stack_level);
        expected_results.push_back(res);
      end
      CMD_CAPTURE: begin
        held = (stack_level < TRACE_SLOTS) ? stack_level : TRACE_SLOTS;
        captures_sent++;
        for (int i = 0; i < TRACE_SLOTS; i++) begin
          res = '0;
          if (i < held) begin
            res.rec = call_stack[stack_level - 1 - i];
          end
          res.slot = SLOT_W'(i);
          res.captured_count = SLOT_W'(held);
          res.depth_now = DEPTH_W'(stack_level);
          res.last_flag = (i == TRACE_SLOTS - 1);
          expected_results.push_back(res);
        end
      end
      default: begin
        res.depth_now = DEPTH_W'(stack_level);
        expected_results.push_back(res);
      end
    endcase
    if (stack_level > peak_level) begin
      peak_level = stack_level;
    end
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input rec_t rec);
    int gap;
    if ($urandom_range(0, 24) == 0) begin
      source_no_idle = ~source_no_idle;
    end
    gap = source_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rec;
    s_axis_tuser <= cmd;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    predict_command(cmd, rec);
    commands_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic rec_t rand_record();
    rec_t rec;
    rec.file_id = rand_word();
    rec.func_num = rand_word();
    rec.type_id = rand_word();
    rec.line_no = rand_word();
    rec.col_num = rand_word();
    return rec;
  endfunction

  // Draws a command by percentage weights for push, pop and capture.
  function automatic logic [CMD_W-1:0] rand_command(input int push_pct, input int pop_pct,
                                                    input int capture_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) return CMD_PUSH;
    if (pick < push_pct + pop_pct) return CMD_POP;
    if (pick < push_pct + pop_pct + capture_pct) return CMD_CAPTURE;
    return CMD_UNUSED;
  endfunction

  task automatic test_directed();
    send_command(CMD_POP, '0);
    send_command(CMD_CAPTURE, '0);
    send_command(CMD_UNUSED, '1);
    send_command(CMD_PUSH, '1);
    send_command(CMD_PUSH, '0);
    send_command(CMD_CAPTURE, '1);
    send_command(CMD_POP, '1);
    send_command(CMD_CAPTURE, '0);
    send_command(CMD_POP, '0);
    send_command(CMD_POP, '0);
    for (int i = 0; i < TRACE_SLOTS; i++) begin
      send_command(CMD_PUSH, rand_record());
    end
    send_command(CMD_CAPTURE, '0);
    send_command(CMD_PUSH, rand_record());
    send_command(CMD_CAPTURE, '0);
  endtask

  task automatic test_random_calls();
    for (int i = 0; i < 70; i++) begin
      send_command(rand_command(45, 30, 15), rand_record());
    end
  endtask

  task automatic test_fill_to_overflow();
    while (stack_level < STACK_DEPTH) begin
      case ($urandom_range(0, 99))
        0, 1, 2, 3, 4: send_command(CMD_CAPTURE, rand_record());
        5, 6, 7: send_command(CMD_UNUSED, rand_record());
        default: send_command(CMD_PUSH, rand_record());
      endcase
    end
    send_command(CMD_PUSH, '1);
    send_command(CMD_CAPTURE, '0);
    for (int i = 0; i < 3; i++) begin
      send_command(CMD_PUSH, rand_record());
    end
    send_command(CMD_UNUSED, '0);
  endtask

  task automatic test_unwind();
    for (int i = 0; i < 50; i++) begin
      send_command(rand_command(20, 60, 15), rand_record());
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // Result checker.
  initial begin
    result_t want;
    rec_t got_rec;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, depth", 32'(m_axis_tdata[176:168]), 32'h0);
        end else begin
          want = expected_results.pop_front();
          got_rec = m_axis_tdata[159:0];
          results_checked++;
          if (m_axis_tuser[0] !== want.status)
            report_mismatch("status", 32'(m_axis_tuser[0]), 32'(want.status));
          if (got_rec.file_id !== want.rec.file_id)
            report_mismatch("rec_file", got_rec.file_id, want.rec.file_id);
          if (got_rec.func_num !== want.rec.func_num)
            report_mismatch("rec_routine", got_rec.func_num, want.rec.func_num);
          if (got_rec.type_id !== want.rec.type_id)
            report_mismatch("rec_type", got_rec.type_id, want.rec.type_id);
          if (got_rec.line_no !== want.rec.line_no)
            report_mismatch("rec_line", got_rec.line_no, want.rec.line_no);
          if (got_rec.col_num !== want.rec.col_num)
            report_mismatch("rec_column", got_rec.col_num, want.rec.col_num);
          if (m_axis_tdata[163:160] !== want.slot)
            report_mismatch("slot", 32'(m_axis_tdata[163:160]), 32'(want.slot));
          if (m_axis_tdata[167:164] !== want.captured_count)
            report_mismatch("captured_count", 32'(m_axis_tdata[167:164]),
                            32'(want.captured_count));
          if (m_axis_tdata[176:168] !== want.depth_now)
            report_mismatch("depth_now", 32'(m_axis_tdata[176:168]), 32'(want.depth_now));
          if (m_axis_tlast !== want.last_flag)
            report_mismatch("last_flag", 32'(m_axis_tlast), 32'(want.last_flag));
        end
      end
    end
  end

  // A new idle count is drawn after every result transaction.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
      results_paced <= 0;
      sink_no_idle = 1'b0;
    end else begin
      sink_draw = sink_wait;
      if (results_paced != results_taken) begin
        if ($urandom_range(0, 24) == 0) begin
          sink_no_idle = ~sink_no_idle;
        end
        sink_draw = sink_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
      results_paced <= results_taken;
      if (sink_draw > 0) begin
        m_axis_tready <= 1'b0;
        sink_wait <= sink_draw - 1;
      end else begin
        m_axis_tready <= 1'b1;
        sink_wait <= 0;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    stack_level = 0;
    commands_sent = 0;
    captures_sent = 0;
    refused_pushes = 0;
    empty_pops = 0;
    peak_level = 0;
    source_no_idle = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_calls();
    test_fill_to_overflow();
    test_unwind();

    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands (%0d captures), checked %0d results.",
             commands_sent, captures_sent, results_checked);
    $display("Peak depth %0d, %0d refused pushes, %0d pops on an empty stack.",
             peak_level, refused_pushes, empty_pops);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
